// File: hw/rtl/priority_voice_allocator_assert.svh
// ----------------------------------------------------------------------------
// Priority voice allocator assertion macros
// Shorthand for clocked assertions with reset masking, used by the checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_VOICE_ALLOCATOR_ASSERT_SVH
`define PRIORITY_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and masked while rst_n is low.
`define PVA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and masked while rst_n is low.
`define PVA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// Priority voice allocator package
// Shared constants, codes, payload types and control structures.
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int VOL_W        = 15;
  localparam int PROD_W       = 2 * VOL_W;
  localparam int PROD_SHIFT   = 10;
  localparam int QIN_W        = PROD_W - PROD_SHIFT;
  localparam int RECIP_W      = 21;
  localparam int QMUL_W       = QIN_W + RECIP_W;
  localparam int RECIP_SHIFT  = 25;
  localparam int QUO_W        = QMUL_W - RECIP_SHIFT;

  localparam logic [VOL_W-1:0]   FULL_SCALE = 15'd25600;
  localparam logic [15:0]        UNIT_PITCH = 16'd256;
  // Rounded-up reciprocal of 25 scaled by two to the 25th; exact for 20-bit inputs.
  localparam logic [RECIP_W-1:0] DIV_RECIP  = 21'd1342178;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOLUME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTED         = 1'd1;

  typedef enum logic [1:0] {
    OP_PLAY     = 2'd0,
    OP_FINISH   = 2'd1,
    OP_STOP_ALL = 2'd2
  } pva_op_t;

  typedef enum logic [2:0] {
    ACT_DROP    = 3'd0,
    ACT_START   = 3'd1,
    ACT_STEAL   = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_STOP    = 3'd4,
    ACT_NONE    = 3'd5
  } pva_action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIND,
    ST_SCAN,
    ST_PICK,
    ST_EMIT_START,
    ST_EMIT_STEAL,
    ST_EMIT_DROP,
    ST_EMIT_REL,
    ST_EMIT_NONE,
    ST_STOP
  } pva_state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [15:0]       sound_id;
    logic signed [15:0] requested_volume;
    logic              request_priority;
    logic              has_settings;
    logic [VOL_W-1:0]  setting_volume;
    logic [15:0]       setting_pitch;
    logic              setting_priority;
    logic [3:0]        finished_channel;
  } pva_in_t;

  typedef struct packed {
    pva_action_t      action;
    logic [3:0]       channel;
    logic [VOL_W-1:0] final_volume;
    logic [15:0]      pitch;
    logic [15:0]      sound_out;
    logic             last;
  } pva_out_t;

  typedef struct packed {
    logic        load;
    logic        find;
    logic        scan;
    logic        emit;
    pva_action_t act;
  } pva_cmd_t;

  typedef struct packed {
    logic [1:0] in_opcode;
    logic       muted;
    logic       eff_pri;
    logic       any_idle;
    logic       any_busy;
    logic       scan_last;
    logic       steal_found;
    logic       stop_last;
    logic       out_free;
  } pva_stat_t;

  function automatic logic [CH_W-1:0] first_set(input logic [NUM_CHANNELS-1:0] m);
    logic [CH_W-1:0] idx;
    idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = CH_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pva_if.sv
// ----------------------------------------------------------------------------
// Priority voice allocator channel interfaces
// Valid/ready channels for requests and for allocation results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_in_if;
  import pva_pkg::*;
  logic    valid;
  logic    ready;
  pva_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pva_out_if;
  import pva_pkg::*;
  logic     valid;
  logic     ready;
  pva_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/priority_voice_allocator.sv
// ----------------------------------------------------------------------------
// Priority voice allocator
// Assigns playback channels to sound requests with priority stealing,
// frees channels on finish events and stops all channels on request.
// ----------------------------------------------------------------------------
// Items are handled one at a time; the request port is ready only while the
// controller is idle, and a finished result waits in the output register
// while the next request is taken. A play request that finds an idle channel
// passes through volume multiply, reciprocal divide, channel pick and delivery.
// A priority request with every channel busy adds a steal search, which visits
// one channel table entry per cycle, followed by a steal pick. A finish event,
// an unknown opcode or a play request while muted goes straight to delivery.
// Stop-all stops the busy channels one at a time, each stopped channel producing
// its own result, and gives a single empty result when no channel is busy. A
// stalled result port holds delivery until the result is taken.
// Configuration writes are taken in any cycle and must only occur when idle.
`default_nettype none

module priority_voice_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pva_in_if.sink                             in_ch,
  pva_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pva_pkg::VOL_W-1:0]     cfg_wdata
);
  import pva_pkg::*;

  pva_cmd_t  cmd;
  pva_stat_t stat;

  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pva_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_ch.payload),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

// File: hw/rtl/pva_ctrl.sv
// ----------------------------------------------------------------------------
// Priority voice allocator controller
// Sequences volume computation, channel search and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pva_pkg::pva_stat_t stat,
  output pva_pkg::pva_cmd_t    cmd
);
  import pva_pkg::*;

  pva_state_t state_r;
  pva_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (stat.in_opcode)
            OP_PLAY:     state_nxt = stat.muted ? ST_EMIT_DROP : ST_MUL;
            OP_FINISH:   state_nxt = ST_EMIT_REL;
            OP_STOP_ALL: state_nxt = stat.any_busy ? ST_STOP : ST_EMIT_NONE;
            default:     state_nxt = ST_EMIT_DROP;
          endcase
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_FIND;
      ST_FIND: begin
        priority if (stat.any_idle) begin
          state_nxt = ST_EMIT_START;
        end else if (stat.eff_pri) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_EMIT_DROP;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: state_nxt = stat.steal_found ? ST_EMIT_STEAL : ST_EMIT_DROP;
      ST_EMIT_START, ST_EMIT_STEAL, ST_EMIT_DROP, ST_EMIT_REL, ST_EMIT_NONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STOP: begin
        if (stat.out_free && stat.stop_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.act  = ACT_DROP;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FIND: cmd.find = 1'b1;
      ST_SCAN: cmd.scan = 1'b1;
      ST_EMIT_START: begin
        cmd.emit = stat.out_free;
        cmd.act  = ACT_START;
      end
      ST_EMIT_STEAL: begin
        cmd.emit = stat.out_free;
        cmd.act  = ACT_STEAL;
      end
      ST_EMIT_DROP: begin
        cmd.emit = stat.out_free;
        cmd.act  = ACT_DROP;
      end
      ST_EMIT_REL: begin
        cmd.emit = stat.out_free;
        cmd.act  = ACT_RELEASE;
      end
      ST_EMIT_NONE: begin
        cmd.emit = stat.out_free;
        cmd.act  = ACT_NONE;
      end
      ST_STOP: begin
        cmd.emit = stat.out_free;
        cmd.act  = ACT_STOP;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/pva_dp.sv
// ----------------------------------------------------------------------------
// Priority voice allocator datapath
// Channel table, volume arithmetic, steal search and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pva_pkg::pva_in_t              in_payload,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pva_pkg::pva_out_t                  out_payload,
  input  wire logic                          cfg_we,
  input  wire logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pva_pkg::VOL_W-1:0]     cfg_wdata,
  input  wire pva_pkg::pva_cmd_t             cmd,
  output pva_pkg::pva_stat_t                 stat
);
  import pva_pkg::*;

  logic [VOL_W-1:0] master_volume_r;
  logic             muted_r;

  logic [NUM_CHANNELS-1:0] busy_r, busy_nxt;
  logic [NUM_CHANNELS-1:0] pri_r, pri_nxt;
  logic [VOL_W-1:0]        vol_r   [NUM_CHANNELS];
  logic [VOL_W-1:0]        vol_nxt [NUM_CHANNELS];

  pva_in_t          in_r;
  logic [PROD_W-1:0] prod_r;
  logic [VOL_W-1:0] fvol_r;
  logic [CH_W-1:0]  pick_r;
  logic [CH_W-1:0]  cnt_r;
  logic             np_found_r, lo_found_r;
  logic [VOL_W-1:0] np_min_r, lo_min_r;
  logic [CH_W-1:0]  np_idx_r, lo_idx_r;
  logic             out_valid_r;
  pva_out_t         out_r, out_nxt;

  logic [VOL_W-1:0]        target;
  logic [QMUL_W-1:0]       qmul;
  logic [QUO_W-1:0]        quo;
  logic                    eff_pri;
  logic [15:0]             pitch;
  logic [CH_W-1:0]         first_idle, first_busy, steal_idx, fin_ch, wr_idx;
  logic [NUM_CHANNELS-1:0] busy_onehot;
  logic                    stop_last;
  logic                    out_free;
  logic [VOL_W-1:0]        cur_vol;
  logic                    wr_en, wr_clear;

  always_comb begin
    priority if (!in_r.requested_volume[15]) begin
      target = in_r.requested_volume[VOL_W-1:0];
    end else if (in_r.has_settings) begin
      target = in_r.setting_volume;
    end else begin
      target = FULL_SCALE;
    end
  end

  assign qmul = {{RECIP_W{1'b0}}, prod_r[PROD_W-1:PROD_SHIFT]}
              * {{QIN_W{1'b0}}, DIV_RECIP};
  assign quo  = qmul[QMUL_W-1:RECIP_SHIFT];

  assign eff_pri = in_r.request_priority & (~in_r.has_settings | in_r.setting_priority);
  assign pitch   = in_r.has_settings ? in_r.setting_pitch : UNIT_PITCH;

  assign first_idle  = first_set(~busy_r);
  assign first_busy  = first_set(busy_r);
  assign busy_onehot = {{(NUM_CHANNELS-1){1'b0}}, 1'b1} << first_busy;
  assign stop_last   = (busy_r & ~busy_onehot) == '0;
  assign steal_idx   = np_found_r ? np_idx_r : lo_idx_r;
  assign fin_ch      = in_r.finished_channel[CH_W-1:0];
  assign out_free    = !out_valid_r || out_ready;
  assign cur_vol     = vol_r[cnt_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_volume_r <= FULL_SCALE;
      muted_r         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MASTER_VOLUME: master_volume_r <= cfg_wdata;
        CFG_MUTED:         muted_r         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_clear = 1'b0;
    wr_idx   = '0;
    if (cmd.emit) begin
      unique case (cmd.act)
        ACT_START: begin
          wr_en  = 1'b1;
          wr_idx = pick_r;
        end
        ACT_STEAL: begin
          wr_en  = 1'b1;
          wr_idx = steal_idx;
        end
        ACT_RELEASE: begin
          wr_clear = 1'b1;
          wr_idx   = fin_ch;
        end
        ACT_STOP: begin
          wr_clear = 1'b1;
          wr_idx   = first_busy;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    pri_nxt  = pri_r;
    vol_nxt  = vol_r;
    priority if (cfg_we && cfg_index == CFG_MUTED && cfg_wdata[0]) begin
      busy_nxt = '0;
      pri_nxt  = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        vol_nxt[i] = '0;
      end
    end else if (wr_en) begin
      busy_nxt[wr_idx] = 1'b1;
      pri_nxt[wr_idx]  = eff_pri;
      vol_nxt[wr_idx]  = fvol_r;
    end else if (wr_clear) begin
      busy_nxt[wr_idx] = 1'b0;
      pri_nxt[wr_idx]  = 1'b0;
      vol_nxt[wr_idx]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      pri_r  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        vol_r[i] <= '0;
      end
    end else begin
      busy_r <= busy_nxt;
      pri_r  <= pri_nxt;
      vol_r  <= vol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_payload;
    end
    prod_r <= {{VOL_W{1'b0}}, target} * {{VOL_W{1'b0}}, master_volume_r};
    fvol_r <= (quo > QUO_W'(FULL_SCALE)) ? FULL_SCALE : quo[VOL_W-1:0];
    if (cmd.find) begin
      pick_r     <= first_idle;
      cnt_r      <= '0;
      np_found_r <= 1'b0;
      lo_found_r <= 1'b0;
    end else if (cmd.scan) begin
      cnt_r <= cnt_r + 1'b1;
      if (!pri_r[cnt_r] && (!np_found_r || cur_vol < np_min_r)) begin
        np_found_r <= 1'b1;
        np_min_r   <= cur_vol;
        np_idx_r   <= cnt_r;
      end
      if (cur_vol < fvol_r && (!lo_found_r || cur_vol < lo_min_r)) begin
        lo_found_r <= 1'b1;
        lo_min_r   <= cur_vol;
        lo_idx_r   <= cnt_r;
      end
    end
  end

  always_comb begin
    out_nxt        = '0;
    out_nxt.action = cmd.act;
    out_nxt.last   = 1'b1;
    unique case (cmd.act)
      ACT_START, ACT_STEAL: begin
        out_nxt.channel      = 4'(wr_idx);
        out_nxt.final_volume = fvol_r;
        out_nxt.pitch        = pitch;
        out_nxt.sound_out    = in_r.sound_id;
      end
      ACT_RELEASE: out_nxt.channel = in_r.finished_channel;
      ACT_STOP: begin
        out_nxt.channel = 4'(first_busy);
        out_nxt.last    = stop_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  always_comb begin
    stat             = '0;
    stat.in_opcode   = in_payload.opcode;
    stat.muted       = muted_r;
    stat.eff_pri     = eff_pri;
    stat.any_idle    = ~&busy_r;
    stat.any_busy    = |busy_r;
    stat.scan_last   = cnt_r == CH_W'(NUM_CHANNELS - 1);
    stat.steal_found = np_found_r | lo_found_r;
    stat.stop_last   = stop_last;
    stat.out_free    = out_free;
  end

endmodule

`default_nettype wire

// File: hw/rtl/pva_checker.sv
// ----------------------------------------------------------------------------
// Priority voice allocator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_voice_allocator_assert.svh"

module pva_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire pva_pkg::pva_out_t out_payload
);
  import pva_pkg::*;

  logic stall_seen;
  logic other_result;
  logic quiet_result;
  logic single_result;
  logic fields_clear;
  logic vol_ok;

  assign stall_seen    = out_valid && !out_ready;
  assign other_result  = out_valid && out_payload.action != ACT_START
                         && out_payload.action != ACT_STEAL;
  assign quiet_result  = out_valid && (out_payload.action == ACT_DROP
                         || out_payload.action == ACT_NONE);
  assign single_result = out_valid && out_payload.action != ACT_STOP;
  assign fields_clear  = out_payload.final_volume == '0 && out_payload.pitch == '0
                         && out_payload.sound_out == '0;
  assign vol_ok        = out_payload.final_volume <= FULL_SCALE;

  `PVA_ASSERT_NXT(a_out_hold, stall_seen, out_valid && $stable(out_payload), "Held result changed.")

  `PVA_ASSERT_IMP(a_idle_fields, other_result, fields_clear, "Playback fields on non-start result.")

  `PVA_ASSERT_IMP(a_drop_channel, quiet_result, out_payload.channel == '0, "Channel set on drop.")

  `PVA_ASSERT_IMP(a_single_last, single_result, out_payload.last, "Single result not marked last.")

  `PVA_ASSERT_IMP(a_volume_clamp, out_valid, vol_ok, "Volume above full scale.")

endmodule

bind priority_voice_allocator pva_checker u_pva_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);

`default_nettype wire
